// File: rtl/core/assert_macros.svh
// Assertion helpers used by the framer core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// File: rtl/core/eebf_pkg.sv
package eebf_pkg;

   // packet and code constants
   localparam int unsigned PACKET_SIZE = 64;
   localparam int unsigned FILL_W      = $clog2(PACKET_SIZE + 1);

   localparam logic [7:0] ESC_CODE = 8'd0;
   localparam logic [7:0] EOI_CODE = 8'd1;

   localparam int unsigned BYTE_W = 8;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_W    = 2;
   localparam logic [1:0]  CSR_EOT_ENABLE = 2'd0;
   localparam logic [1:0]  CSR_EOS_MODE   = 2'd1;
   localparam logic [1:0]  CSR_EOS_CHAR   = 2'd2;

   // result slots of one item, emitted lowest first
   localparam int unsigned SLOT_PRE_BND  = 0;
   localparam int unsigned SLOT_PREFIX   = 1;
   localparam int unsigned SLOT_DATA     = 2;
   localparam int unsigned SLOT_POST_BND = 3;
   localparam int unsigned NUM_SLOTS     = 4;

   typedef enum logic [1:0] {
      EOS_OFF  = 2'd0,
      EOS_7BIT = 2'd1,
      EOS_8BIT = 2'd2
   } eos_mode_type;

   typedef struct packed {
      logic         eot_enable;
      eos_mode_type eos_mode;
      logic [7:0]   eos_char;
   } cfg_type;

   typedef struct packed {
      logic [NUM_SLOTS-1:0] pend;
      logic [7:0]           prefix_code;
      logic [7:0]           data;
   } plan_type;

endpackage

// File: rtl/core/eebf_req_if.sv
interface eebf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       message_end;

   modport source (output valid, output data_byte, output message_end, input ready);
   modport sink   (input valid, input data_byte, input message_end, output ready);
endinterface

// File: rtl/core/eebf_rsp_if.sv
interface eebf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       boundary;
   logic       run_last;

   modport source (output valid, output out_byte, output boundary, output run_last,
                   input ready);
   modport sink   (input valid, input out_byte, input boundary, input run_last,
                   output ready);
endinterface

// File: rtl/core/eebf_csr_if.sv
interface eebf_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] reg_index;
   logic [7:0] wdata;

   modport source (output valid, output reg_index, output wdata, input ready);
   modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// File: rtl/core/eebf_frame_plan.sv
// Decides the results of one byte and the packet fill after it.
module eebf_frame_plan (
   input  eebf_pkg::cfg_type              cfg,
   input  logic [7:0]                     data_byte,
   input  logic                           message_end,
   input  logic [eebf_pkg::FILL_W-1:0]    fill,
   output eebf_pkg::plan_type             plan,
   output logic [eebf_pkg::FILL_W-1:0]    fill_next
);

   logic                         eos_hit;
   logic                         eoi_pre;
   logic                         esc_pre;
   logic                         has_prefix;
   logic [eebf_pkg::FILL_W:0]    need;
   logic                         no_room;
   logic [eebf_pkg::FILL_W-1:0]  base;

   // end-of-string compare; unused mode code turns it off
   always_comb begin
      unique case (cfg.eos_mode)
         eebf_pkg::EOS_7BIT: eos_hit = (data_byte[6:0] == cfg.eos_char[6:0]);
         eebf_pkg::EOS_8BIT: eos_hit = (data_byte == cfg.eos_char);
         default:            eos_hit = 1'b0;
      endcase
   end

   // EOI prefix wins over ESC
   assign eoi_pre    = (cfg.eot_enable && message_end) || eos_hit;
   assign esc_pre    = !eoi_pre &&
                       (data_byte == eebf_pkg::ESC_CODE || data_byte == eebf_pkg::EOI_CODE);
   assign has_prefix = eoi_pre || esc_pre;

   // fit check counts the prefix, byte and prefix are never split
   assign need    = {1'b0, fill} + (eebf_pkg::FILL_W+1)'(has_prefix)
                    + (eebf_pkg::FILL_W+1)'(1);
   assign no_room = need > (eebf_pkg::FILL_W+1)'(eebf_pkg::PACKET_SIZE);
   assign base    = no_room ? '0 : fill;

   // message end always leaves a non-empty packet, so it always closes
   assign fill_next = message_end ? '0
                    : base + eebf_pkg::FILL_W'(has_prefix) + eebf_pkg::FILL_W'(1);

   always_comb begin
      plan.pend                          = '0;
      plan.pend[eebf_pkg::SLOT_PRE_BND]  = no_room;
      plan.pend[eebf_pkg::SLOT_PREFIX]   = has_prefix;
      plan.pend[eebf_pkg::SLOT_DATA]     = 1'b1;
      plan.pend[eebf_pkg::SLOT_POST_BND] = message_end;
      plan.prefix_code = eoi_pre ? eebf_pkg::EOI_CODE : eebf_pkg::ESC_CODE;
      plan.data        = data_byte;
   end

endmodule

// File: rtl/core/escape_eoi_byte_framer_core.sv
// Channel  Dir  Handshake     Payload
// req_bus  in   valid/ready   data_byte[7:0], message_end
// rsp_bus  out  valid/ready   out_byte[7:0], boundary, run_last
// csr_bus  in   valid/ready   reg_index[1:0], wdata[7:0] (always ready)
//
// Each byte yields one to four words, sent one per cycle from the result
// register while rsp_bus is ready; the slot sequencer works through them in
// slot order, and the next byte is taken in the cycle its last word is loaded.
// Synchronous active-high reset clears config, packet fill and valid flags.
// A stalled rsp_bus holds the result register and blocks new bytes once the
// pending word list cannot drain.
`include "assert_macros.svh"

module escape_eoi_byte_framer_core (
   input  logic        clock,
   input  logic        reset,
   eebf_req_if.sink    req_bus,
   eebf_rsp_if.source  rsp_bus,
   eebf_csr_if.sink    csr_bus
);

   eebf_pkg::cfg_type                cfg_ff;
   eebf_pkg::plan_type               plan_ff, plan_in, new_plan;
   logic [eebf_pkg::FILL_W-1:0]      fill_ff, fill_in, fill_next;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [7:0]                       rsp_byte_ff, rsp_byte_in;
   logic                             rsp_bnd_ff, rsp_bnd_in;
   logic                             rsp_last_ff, rsp_last_in;
   logic                             out_load;
   logic                             emit;
   logic                             req_fire;
   logic [eebf_pkg::NUM_SLOTS-1:0]   sel;
   logic [eebf_pkg::NUM_SLOTS-1:0]   pend_rest;

   // configuration writes
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.eot_enable <= 1'b0;
         cfg_ff.eos_mode   <= eebf_pkg::EOS_OFF;
         cfg_ff.eos_char   <= '0;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.reg_index)
            eebf_pkg::CSR_EOT_ENABLE: cfg_ff.eot_enable <= csr_bus.wdata[0];
            eebf_pkg::CSR_EOS_MODE:
               cfg_ff.eos_mode <= eebf_pkg::eos_mode_type'(csr_bus.wdata[1:0]);
            eebf_pkg::CSR_EOS_CHAR:   cfg_ff.eos_char <= csr_bus.wdata;
            default: ;
         endcase
      end
   end

   eebf_frame_plan u_plan (
      .cfg         (cfg_ff),
      .data_byte   (req_bus.data_byte),
      .message_end (req_bus.message_end),
      .fill        (fill_ff),
      .plan        (new_plan),
      .fill_next   (fill_next)
   );

   // slot sequencer: lowest pending slot goes out first
   assign out_load  = !rsp_valid_ff || rsp_bus.ready;
   assign emit      = (plan_ff.pend != '0) && out_load;
   assign sel       = plan_ff.pend & (~plan_ff.pend + eebf_pkg::NUM_SLOTS'(1));
   assign pend_rest = plan_ff.pend & ~sel;

   assign req_bus.ready = (plan_ff.pend == '0) || (emit && pend_rest == '0);
   assign req_fire      = req_bus.valid && req_bus.ready;

   always_comb begin
      plan_in = plan_ff;
      fill_in = fill_ff;
      if (req_fire) begin
         plan_in = new_plan;
         fill_in = fill_next;
      end else if (emit) begin
         plan_in.pend = pend_rest;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_bnd_in   = rsp_bnd_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_bnd_in   = sel[eebf_pkg::SLOT_PRE_BND] || sel[eebf_pkg::SLOT_POST_BND];
         rsp_last_in  = (pend_rest == '0);
         priority if (sel[eebf_pkg::SLOT_PREFIX]) begin
            rsp_byte_in = plan_ff.prefix_code;
         end else if (sel[eebf_pkg::SLOT_DATA]) begin
            rsp_byte_in = plan_ff.data;
         end else begin
            rsp_byte_in = '0;
         end
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plan_ff.pend <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         plan_ff      <= plan_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
      rsp_bnd_ff  <= rsp_bnd_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.out_byte = rsp_byte_ff;
   assign rsp_bus.boundary = rsp_bnd_ff;
   assign rsp_bus.run_last = rsp_last_ff;

   // checks
   `ASSERT_IMPLY(a_fill_bound, clock, reset, 1'b1,
                 fill_ff <= eebf_pkg::FILL_W'(eebf_pkg::PACKET_SIZE))
   `ASSERT_NEXT(a_msg_end_empties, clock, reset, req_fire && req_bus.message_end,
                fill_ff == '0)
   `ASSERT_IMPLY(a_accept_drained, clock, reset, req_fire,
                 plan_ff.pend == '0 || (out_load && $onehot(plan_ff.pend)))
   `ASSERT_IMPLY(a_bnd_zero_byte, clock, reset, rsp_valid_ff && rsp_bnd_ff,
                 rsp_byte_ff == '0)

endmodule

// File: test/tb_escape_eoi_byte_framer_core.sv
module tb_escape_eoi_byte_framer_core;
   timeunit 1ns;
   timeprecision 1ps;

   // mode value the block leaves unused: compare is off
   localparam logic [1:0] EOS_UNUSED  = 2'd3;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned DRAIN_SLACK = 12;
   localparam int unsigned MAX_REPORTS = 10;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       boundary;
      logic       run_last;
   } framed_word_type;

   logic clock;
   logic reset;

   eebf_req_if req_bus ();
   eebf_rsp_if rsp_bus ();
   eebf_csr_if csr_bus ();

   escape_eoi_byte_framer_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // framer state as the predictor sees it
   logic        cfg_eot;
   logic [1:0]  cfg_eos_mode;
   logic [7:0]  cfg_eos_char;
   int unsigned fill_count;

   framed_word_type expected_words[$];
   int unsigned  mismatch_count;
   int unsigned  cycle_count;
   int unsigned  send_idle_pct;
   int unsigned  recv_idle_pct;
   int unsigned  rsp_hold_request;

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[escape_eoi_byte_framer_core] ERROR");
         $finish;
      end
   end

   // predict the words one input byte produces
   function automatic void predict_framing(input logic [7:0] b, input logic last);
      logic            eos_hit;
      logic            eoi_pre;
      logic            esc_pre;
      int unsigned     pre_len;
      framed_word_type words[$];
      framed_word_type w;
      eos_hit = 1'b0;
      case (cfg_eos_mode)
         eebf_pkg::EOS_7BIT: eos_hit = (b[6:0] == cfg_eos_char[6:0]);
         eebf_pkg::EOS_8BIT: eos_hit = (b == cfg_eos_char);
         default:            eos_hit = 1'b0;
      endcase
      eoi_pre = (cfg_eot && last) || eos_hit;
      esc_pre = !eoi_pre && (b == eebf_pkg::ESC_CODE || b == eebf_pkg::EOI_CODE);
      pre_len = (eoi_pre || esc_pre) ? 1 : 0;
      // byte and prefix stay in one packet
      if (fill_count + pre_len + 1 > eebf_pkg::PACKET_SIZE) begin
         w = '{out_byte: 8'h00, boundary: 1'b1, run_last: 1'b0};
         words.push_back(w);
         fill_count = 0;
      end
      if (pre_len != 0) begin
         w = '{out_byte: (eoi_pre ? eebf_pkg::EOI_CODE : eebf_pkg::ESC_CODE),
               boundary: 1'b0, run_last: 1'b0};
         words.push_back(w);
         fill_count++;
      end
      w = '{out_byte: b, boundary: 1'b0, run_last: 1'b0};
      words.push_back(w);
      fill_count++;
      if (last && fill_count > 0) begin
         w = '{out_byte: 8'h00, boundary: 1'b1, run_last: 1'b0};
         words.push_back(w);
         fill_count = 0;
      end
      words[words.size()-1].run_last = 1'b1;
      foreach (words[i]) expected_words.push_back(words[i]);
   endfunction

   // result receiver: random stalls plus an optional long hold
   initial begin
      int unsigned hold_left;
      hold_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_request != 0) begin
            hold_left = rsp_hold_request;
            rsp_hold_request = 0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // compare each accepted word with the oldest prediction
   always @(posedge clock) begin
      framed_word_type seen;
      framed_word_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen.out_byte = rsp_bus.out_byte;
         seen.boundary = rsp_bus.boundary;
         seen.run_last = rsp_bus.run_last;
         if (expected_words.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected word: byte=%h boundary=%b run_last=%b",
                        seen.out_byte, seen.boundary, seen.run_last);
         end else begin
            want = expected_words.pop_front();
            if (seen.out_byte !== want.out_byte || seen.boundary !== want.boundary ||
                seen.run_last !== want.run_last) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("word mismatch: expected %h/%b/%b, got %h/%b/%b",
                           want.out_byte, want.boundary, want.run_last,
                           seen.out_byte, seen.boundary, seen.run_last);
            end
         end
      end
   end

   // offer one byte, predict on acceptance; valid stays up for a back-to-back byte
   task automatic send_byte(input logic [7:0] b, input logic last);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.data_byte   <= b;
      req_bus.message_end <= last;
      do @(posedge clock); while (!req_bus.ready);
      predict_framing(b, last);
   endtask

   // sender pauses until every predicted word has come back
   task automatic wait_results_drained();
      req_bus.valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [7:0] value);
      csr_bus.valid     <= 1'b1;
      csr_bus.reg_index <= index;
      csr_bus.wdata     <= value;
      do @(posedge clock); while (!csr_bus.ready);
      case (index)
         eebf_pkg::CSR_EOT_ENABLE: cfg_eot      = value[0];
         eebf_pkg::CSR_EOS_MODE:   cfg_eos_mode = value[1:0];
         eebf_pkg::CSR_EOS_CHAR:   cfg_eos_char = value;
         default: ;
      endcase
   endtask

   // reprogram all three registers with the framer idle
   task automatic apply_settings(input logic [7:0] eot_w, input logic [7:0] mode_w,
                                 input logic [7:0] char_w);
      wait_results_drained();
      write_csr(eebf_pkg::CSR_EOT_ENABLE, eot_w);
      write_csr(eebf_pkg::CSR_EOS_MODE, mode_w);
      write_csr(eebf_pkg::CSR_EOS_CHAR, char_w);
      csr_bus.valid <= 1'b0;
   endtask

   // bytes skewed toward the codes and the end-of-string character
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(9))
         0:       return eebf_pkg::ESC_CODE;
         1:       return eebf_pkg::EOI_CODE;
         2:       return cfg_eos_char;
         3:       return cfg_eos_char ^ 8'h80;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [7:0] pick_eos_char();
      case ($urandom_range(5))
         0:       return 8'h00;
         1:       return 8'h01;
         2:       return 8'h7f;
         3:       return 8'h80;
         4:       return 8'hff;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic send_message(input int unsigned len);
      for (int unsigned i = 0; i < len; i++) send_byte(pick_byte(), i == len - 1);
   endtask

   // reset settings: no EOT, compare off, codes get ESC
   task automatic test_reset_defaults();
      send_byte(eebf_pkg::ESC_CODE, 1'b0);
      send_byte(eebf_pkg::EOI_CODE, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h7f, 1'b0);
      send_byte(8'h55, 1'b1);
   endtask

   // prefix selection under each compare mode
   task automatic test_prefix_rules();
      // seven-bit compare; EOT on a code byte wins over ESC
      apply_settings(8'd1, {6'd0, eebf_pkg::EOS_7BIT}, 8'h85);
      send_byte(8'h05, 1'b0);
      send_byte(8'h85, 1'b0);
      send_byte(eebf_pkg::EOI_CODE, 1'b0);
      send_byte(eebf_pkg::ESC_CODE, 1'b1);
      // eight-bit compare on the ESC code; trailing boundary without EOT
      apply_settings(8'd0, {6'd0, eebf_pkg::EOS_8BIT}, eebf_pkg::ESC_CODE);
      send_byte(eebf_pkg::ESC_CODE, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(eebf_pkg::EOI_CODE, 1'b1);
      // unused mode: compare disabled
      apply_settings(8'd1, {6'd0, EOS_UNUSED}, 8'h41);
      send_byte(8'h41, 1'b0);
      send_byte(eebf_pkg::ESC_CODE, 1'b0);
      send_byte(8'h41, 1'b1);
      // high bits of the registers are dropped
      apply_settings(8'hfe, {6'b111101, eebf_pkg::EOS_8BIT}, 8'hff);
      send_byte(8'hff, 1'b0);
      send_byte(8'h7f, 1'b1);
      // one-byte message with EOT
      apply_settings(8'd1, {6'd0, eebf_pkg::EOS_OFF}, 8'hff);
      send_byte(8'hff, 1'b1);
   endtask

   // a string match at a nearly full packet must push its pair to the next one
   task automatic test_packet_fill();
      apply_settings(8'd1, {6'd0, eebf_pkg::EOS_8BIT}, 8'haa);
      for (int unsigned i = 0; i < eebf_pkg::PACKET_SIZE - 1; i++) send_byte(8'h20, 1'b0);
      send_byte(8'haa, 1'b0);
      send_byte(8'h20, 1'b1);
   endtask

   task automatic run_random_traffic(input int unsigned item_goal);
      int unsigned sent;
      int unsigned msg_count;
      int unsigned len;
      sent = 0;
      while (sent < item_goal) begin
         apply_settings(8'($urandom_range(255)), 8'($urandom_range(255)), pick_eos_char());
         msg_count = $urandom_range(2, 5);
         for (int unsigned m = 0; m < msg_count && sent < item_goal; m++) begin
            len = ($urandom_range(5) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 12);
            if (len > item_goal - sent) len = item_goal - sent;
            send_message(len);
            sent += len;
         end
      end
   endtask

   // receiver holds off while bytes keep coming, so the input stalls
   task automatic test_backpressure();
      apply_settings(8'd1, {6'd0, eebf_pkg::EOS_7BIT}, eebf_pkg::EOI_CODE);
      rsp_hold_request = 400;
      for (int unsigned m = 0; m < 8; m++) send_message(5);
      wait_results_drained();
   endtask

   initial begin
      req_bus.valid       <= 1'b0;
      req_bus.data_byte   <= 8'h00;
      req_bus.message_end <= 1'b0;
      csr_bus.valid       <= 1'b0;
      csr_bus.reg_index   <= eebf_pkg::CSR_EOT_ENABLE;
      csr_bus.wdata       <= 8'h00;
      reset               <= 1'b1;
      cfg_eot          = 1'b0;
      cfg_eos_mode     = eebf_pkg::EOS_OFF;
      cfg_eos_char     = 8'h00;
      fill_count       = 0;
      mismatch_count   = 0;
      rsp_hold_request = 0;
      send_idle_pct    = 8;
      recv_idle_pct    = 59;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_prefix_rules();
      test_packet_fill();
      run_random_traffic(50);

      send_idle_pct = 59;
      recv_idle_pct = 8;
      run_random_traffic(50);
      test_backpressure();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random_traffic(56);

      wait_results_drained();
      if (mismatch_count == 0) begin
         $display("[escape_eoi_byte_framer_core] OK");
      end else begin
         $display("[escape_eoi_byte_framer_core] ERROR");
      end
      $finish;
   end

endmodule
